// ----- sv/risc_operation_executor_assert.svh -----
// Assertion macros shared by the executor RTL.
`ifndef RISC_OPERATION_EXECUTOR_ASSERT_SVH
`define RISC_OPERATION_EXECUTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ROX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ROX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rox_pkg.sv -----
package rox_pkg;

    localparam int NUM_REGS  = 256;
    localparam int MEM_BYTES = 65536;
    localparam int REG_AW    = $clog2(NUM_REGS);
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int ROWS      = MEM_BYTES / 4;
    localparam int ROW_AW    = MEM_AW - 2;
    localparam int CLR_N     = (ROWS > NUM_REGS) ? ROWS : NUM_REGS;
    localparam int CLR_AW    = $clog2(CLR_N);

    localparam logic [31:0] LAST_WORD_ADDR = 32'(MEM_BYTES - 4);
    localparam logic [31:0] MEM_LIMIT      = 32'(MEM_BYTES - 1);

    // operation codes
    localparam logic [5:0] OP_NOP      = 6'd0;
    localparam logic [5:0] OP_ADD      = 6'd3;
    localparam logic [5:0] OP_SUB      = 6'd4;
    localparam logic [5:0] OP_MULT     = 6'd5;
    localparam logic [5:0] OP_DIV      = 6'd6;
    localparam logic [5:0] OP_ADDI     = 6'd7;
    localparam logic [5:0] OP_SUBI     = 6'd8;
    localparam logic [5:0] OP_MULTI    = 6'd9;
    localparam logic [5:0] OP_DIVI     = 6'd10;
    localparam logic [5:0] OP_LSHIFT   = 6'd11;
    localparam logic [5:0] OP_LSHIFTI  = 6'd12;
    localparam logic [5:0] OP_RSHIFT   = 6'd13;
    localparam logic [5:0] OP_RSHIFTI  = 6'd14;
    localparam logic [5:0] OP_AND      = 6'd15;
    localparam logic [5:0] OP_OR       = 6'd16;
    localparam logic [5:0] OP_XOR      = 6'd17;
    localparam logic [5:0] OP_LOADI    = 6'd18;
    localparam logic [5:0] OP_LOAD     = 6'd19;
    localparam logic [5:0] OP_LOADAI   = 6'd20;
    localparam logic [5:0] OP_LOADAO   = 6'd21;
    localparam logic [5:0] OP_CLOAD    = 6'd22;
    localparam logic [5:0] OP_CLOADAI  = 6'd23;
    localparam logic [5:0] OP_CLOADAO  = 6'd24;
    localparam logic [5:0] OP_STORE    = 6'd25;
    localparam logic [5:0] OP_STOREAI  = 6'd26;
    localparam logic [5:0] OP_STOREAO  = 6'd27;
    localparam logic [5:0] OP_CSTORE   = 6'd28;
    localparam logic [5:0] OP_CSTOREAI = 6'd29;
    localparam logic [5:0] OP_CSTOREAO = 6'd30;
    localparam logic [5:0] OP_BR       = 6'd31;
    localparam logic [5:0] OP_CBR      = 6'd32;
    localparam logic [5:0] OP_CMPLT    = 6'd33;
    localparam logic [5:0] OP_CMPLE    = 6'd34;
    localparam logic [5:0] OP_CMPEQ    = 6'd35;
    localparam logic [5:0] OP_CMPNE    = 6'd36;
    localparam logic [5:0] OP_CMPGE    = 6'd37;
    localparam logic [5:0] OP_CMPGT    = 6'd38;
    localparam logic [5:0] OP_I2I      = 6'd39;
    localparam logic [5:0] OP_C2C      = 6'd40;
    localparam logic [5:0] OP_C2I      = 6'd41;
    localparam logic [5:0] OP_I2C      = 6'd42;
    localparam logic [5:0] OP_OUTPUT   = 6'd43;
    localparam logic [5:0] OP_COUTPUT  = 6'd44;
    localparam logic [5:0] OP_OUTPUTAI = 6'd45;

    // result kinds
    localparam logic [2:0] K_NONE   = 3'd0;
    localparam logic [2:0] K_REG    = 3'd1;
    localparam logic [2:0] K_MEM    = 3'd2;
    localparam logic [2:0] K_DISP   = 3'd3;
    localparam logic [2:0] K_BRANCH = 3'd4;
    localparam logic [2:0] K_ERR    = 3'd5;

    typedef struct packed {
        logic [5:0]         mode;
        logic [7:0]         src_a;
        logic [7:0]         src_b;
        logic [7:0]         dst_a;
        logic [7:0]         dst_b;
        logic signed [31:0] imm;
        logic [15:0]        label_taken;
        logic [15:0]        label_fallthrough;
    } op_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [15:0]        location;
        logic [15:0]        target;
    } res_t;

    function automatic logic [31:0] sext8(logic [7:0] b);
        sext8 = {{24{b[7]}}, b};
    endfunction

    function automatic logic [REG_AW-1:0] reg_idx(logic [7:0] i);
        reg_idx = REG_AW'({24'd0, i} % NUM_REGS);
    endfunction

endpackage

// ----- sv/risc_operation_executor.sv -----
// Steps: the operand registers are read in S_RA to S_RD, the address is formed in
// S_ADDR and S_EXEC executes; loads and outputs add a memory read in S_MEM, a divide
// runs 32 restoring steps in S_DIV, and S_DONE registers the result, waiting while
// the result is stalled. One operation in flight: the next transaction is taken in
// the cycle after the result is registered. Reset: a clearing pass zeroes the byte
// memory banks and the register file; op_stall stays high meanwhile.
module risc_operation_executor
    import rox_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic op_valid,
    output logic op_stall,
    input  op_t  op,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

`include "risc_operation_executor_assert.svh"

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RA    = 4'd2;
    localparam logic [3:0] S_RB    = 4'd3;
    localparam logic [3:0] S_RC    = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_ADDR  = 4'd6;
    localparam logic [3:0] S_EXEC  = 4'd7;
    localparam logic [3:0] S_MEM   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [CLR_AW-1:0] clr_cnt_reg;
    op_t               op_reg;
    logic [31:0]       opa_reg, opb_reg, base_reg, offs_reg;
    logic [31:0]       y_reg, addr_reg;
    logic              ok_w_reg, ok_b_reg;
    logic [2:0]        kind_reg;
    logic [31:0]       val_reg;
    logic [15:0]       loc_reg, tgt_reg;
    logic [31:0]       div_rem_reg, div_quo_reg, div_dvs_reg;
    logic              div_neg_reg;
    logic [4:0]        div_cnt_reg;
    logic              res_valid_reg;
    res_t              res_reg;

    // register file
    logic [31:0]       rf [NUM_REGS];
    logic [31:0]       rf_q;
    logic [REG_AW-1:0] rf_raddr, rf_waddr;
    logic [31:0]       rf_wdata;
    logic              rf_we;

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf[rf_waddr] <= rf_wdata;
        rf_q <= rf[rf_raddr];
    end

    // byte memory: four byte banks so an unaligned big-endian word is one access
    logic [ROW_AW-1:0] bank_row [4];
    logic [7:0]        bank_wd  [4];
    logic [3:0]        bank_we;
    logic [7:0]        bank_q   [4];

    for (genvar j = 0; j < 4; j++)
    begin : g_bank
        logic [7:0] mem [ROWS];
        always_ff @(posedge clk)
        begin
            if (bank_we[j])
                mem[bank_row[j]] <= bank_wd[j];
            bank_q[j] <= mem[bank_row[j]];
        end
    end

    logic [1:0]        a0;
    logic [ROW_AW-1:0] row0;
    logic              is_word, st_word;
    logic              mem_wr;

    assign a0   = addr_reg[1:0];
    assign row0 = addr_reg[MEM_AW-1:2];

    always_comb
    begin
        rf_raddr = reg_idx(op_reg.src_a);
        unique case (state_reg)
            S_IDLE:  rf_raddr = reg_idx(op.src_a);
            S_RA:    rf_raddr = reg_idx(op_reg.src_b);
            S_RB:    rf_raddr = reg_idx(op_reg.dst_a);
            S_RC:    rf_raddr = reg_idx(op_reg.dst_b);
            default: rf_raddr = reg_idx(op_reg.src_a);
        endcase
    end

    assign is_word  = (op_reg.mode >= OP_LOAD && op_reg.mode <= OP_LOADAO)
                   || (op_reg.mode >= OP_STORE && op_reg.mode <= OP_STOREAO)
                   || op_reg.mode == OP_OUTPUT || op_reg.mode == OP_OUTPUTAI;
    assign st_word  = op_reg.mode >= OP_STORE && op_reg.mode <= OP_STOREAO;

    // address formation
    logic [31:0] addr_c;
    always_comb
    begin
        priority case (op_reg.mode)
            OP_LOAD, OP_CLOAD:           addr_c = opa_reg;
            OP_LOADAI, OP_CLOADAI:       addr_c = opa_reg + op_reg.imm;
            OP_LOADAO, OP_CLOADAO:       addr_c = opa_reg + opb_reg;
            OP_STORE, OP_CSTORE:         addr_c = base_reg;
            OP_STOREAI, OP_CSTOREAI:     addr_c = base_reg + op_reg.imm;
            OP_STOREAO, OP_CSTOREAO:     addr_c = base_reg + offs_reg;
            OP_OUTPUTAI:                 addr_c = op_reg.imm + opa_reg;
            default:                     addr_c = op_reg.imm;
        endcase
    end

    // execute
    logic [2:0]  ex_kind;
    logic [31:0] ex_val;
    logic [15:0] ex_loc, ex_tgt;
    logic        ex_rd, ex_div;
    logic        ok;
    logic        lt_ab, lt_ba;
    logic [31:0] prod;

    assign ok    = is_word ? ok_w_reg : ok_b_reg;
    assign lt_ab = $signed(opa_reg) < $signed(opb_reg);
    assign lt_ba = $signed(opb_reg) < $signed(opa_reg);
    assign prod  = opa_reg * y_reg;

    always_comb
    begin
        ex_kind = K_NONE;
        ex_val  = 32'd0;
        ex_loc  = 16'(reg_idx(op_reg.dst_a));
        ex_tgt  = 16'd0;
        ex_rd   = 1'b0;
        ex_div  = 1'b0;
        mem_wr  = 1'b0;
        unique case (op_reg.mode)
            OP_ADD, OP_ADDI:     begin ex_kind = K_REG; ex_val = opa_reg + y_reg; end
            OP_SUB, OP_SUBI:     begin ex_kind = K_REG; ex_val = opa_reg - y_reg; end
            OP_MULT, OP_MULTI:   begin ex_kind = K_REG; ex_val = prod; end
            OP_DIV, OP_DIVI:
            begin
                if (y_reg == 32'd0)
                    ex_kind = K_ERR;
                else
                begin
                    ex_kind = K_REG;
                    ex_div  = 1'b1;
                end
            end
            OP_LSHIFT, OP_LSHIFTI:
            begin
                ex_kind = K_REG;
                ex_val  = opa_reg << y_reg[4:0];
            end
            OP_RSHIFT, OP_RSHIFTI:
            begin
                ex_kind = K_REG;
                ex_val  = 32'($signed(opa_reg) >>> y_reg[4:0]);
            end
            OP_AND:   begin ex_kind = K_REG; ex_val = opa_reg & opb_reg; end
            OP_OR:    begin ex_kind = K_REG; ex_val = opa_reg | opb_reg; end
            OP_XOR:   begin ex_kind = K_REG; ex_val = opa_reg ^ opb_reg; end
            OP_LOADI: begin ex_kind = K_REG; ex_val = op_reg.imm; end
            OP_LOAD, OP_LOADAI, OP_LOADAO, OP_CLOAD, OP_CLOADAI, OP_CLOADAO:
            begin
                ex_kind = ok ? K_REG : K_ERR;
                ex_rd   = ok;
            end
            OP_STORE, OP_STOREAI, OP_STOREAO, OP_CSTORE, OP_CSTOREAI, OP_CSTOREAO:
            begin
                ex_kind = ok ? K_MEM : K_ERR;
                mem_wr  = ok;
                ex_val  = ok ? (st_word ? opa_reg : sext8(opa_reg[7:0])) : 32'd0;
                ex_loc  = addr_reg[15:0];
            end
            OP_BR:    begin ex_kind = K_BRANCH; ex_tgt = op_reg.label_taken; end
            OP_CBR:
            begin
                ex_kind = K_BRANCH;
                ex_tgt  = (opa_reg != 32'd0) ? op_reg.label_taken
                                             : op_reg.label_fallthrough;
            end
            OP_CMPLT: begin ex_kind = K_REG; ex_val = {31'd0, lt_ab}; end
            OP_CMPLE: begin ex_kind = K_REG; ex_val = {31'd0, !lt_ba}; end
            OP_CMPEQ: begin ex_kind = K_REG; ex_val = {31'd0, opa_reg == opb_reg}; end
            OP_CMPNE: begin ex_kind = K_REG; ex_val = {31'd0, opa_reg != opb_reg}; end
            OP_CMPGE: begin ex_kind = K_REG; ex_val = {31'd0, !lt_ab}; end
            OP_CMPGT: begin ex_kind = K_REG; ex_val = {31'd0, lt_ba}; end
            OP_I2I:   begin ex_kind = K_REG; ex_val = opa_reg; end
            OP_C2C, OP_C2I, OP_I2C:
            begin
                ex_kind = K_REG;
                ex_val  = sext8(opa_reg[7:0]);
            end
            OP_OUTPUT, OP_COUTPUT, OP_OUTPUTAI:
            begin
                ex_kind = ok ? K_DISP : K_ERR;
                ex_rd   = ok;
            end
            default: ex_kind = K_NONE;
        endcase
        if (ex_kind != K_REG && ex_kind != K_MEM)
            ex_loc = 16'd0;
    end

    // bank control
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            logic [1:0] k;
            k = 2'(j) - a0;
            bank_row[j] = (2'(j) >= a0) ? row0 : row0 + 1'b1;
            bank_wd[j]  = st_word ? 8'(opa_reg >> {~k, 3'b000}) : opa_reg[7:0];
            bank_we[j]  = (state_reg == S_EXEC) && mem_wr && (st_word || 2'(j) == a0);
            if (state_reg == S_CLEAR)
            begin
                bank_row[j] = clr_cnt_reg[ROW_AW-1:0];
                bank_wd[j]  = 8'd0;
                bank_we[j]  = {1'b0, clr_cnt_reg} < (CLR_AW + 1)'(ROWS);
            end
        end
    end

    logic [31:0] mem_word, mem_val;
    assign mem_word = {bank_q[a0], bank_q[a0 + 2'd1], bank_q[a0 + 2'd2], bank_q[a0 + 2'd3]};
    assign mem_val  = is_word ? mem_word : sext8(bank_q[a0]);

    // restoring divide step on magnitudes
    logic [32:0] div_sh;
    logic        div_ge;
    logic [31:0] div_rem_n, div_quo_n;
    assign div_sh    = {div_rem_reg, div_quo_reg[31]};
    assign div_ge    = div_sh >= {1'b0, div_dvs_reg};
    assign div_rem_n = div_ge ? 32'(div_sh - {1'b0, div_dvs_reg}) : div_sh[31:0];
    assign div_quo_n = {div_quo_reg[30:0], div_ge};

    logic out_free;
    assign out_free = !res_valid_reg || !res_stall;

    assign rf_we    = (state_reg == S_CLEAR) ? ({1'b0, clr_cnt_reg} < (CLR_AW + 1)'(NUM_REGS))
                    : (state_reg == S_DONE && out_free && kind_reg == K_REG);
    assign rf_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg[REG_AW-1:0]
                                             : loc_reg[REG_AW-1:0];
    assign rf_wdata = (state_reg == S_CLEAR) ? 32'd0 : val_reg;

    assign op_stall  = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_cnt_reg == CLR_AW'(CLR_N - 1)) state_next = S_IDLE;
            S_IDLE:  if (op_valid) state_next = S_RA;
            S_RA:    state_next = S_RB;
            S_RB:    state_next = S_RC;
            S_RC:    state_next = S_RD;
            S_RD:    state_next = S_ADDR;
            S_ADDR:  state_next = S_EXEC;
            S_EXEC:  state_next = ex_div ? S_DIV : (ex_rd ? S_MEM : S_DONE);
            S_MEM:   state_next = S_DONE;
            S_DIV:   if (div_cnt_reg == 5'd31) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (state_reg == S_DIV)
                div_cnt_reg <= div_cnt_reg + 1'b1;
            else
                div_cnt_reg <= '0;
            if (state_reg == S_DONE && out_free)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE: if (op_valid) op_reg <= op;
            S_RA:   opa_reg  <= rf_q;
            S_RB:   opb_reg  <= rf_q;
            S_RC:   base_reg <= rf_q;
            S_RD:   offs_reg <= rf_q;
            S_ADDR:
            begin
                addr_reg <= addr_c;
                ok_w_reg <= addr_c <= LAST_WORD_ADDR;
                ok_b_reg <= addr_c <= MEM_LIMIT;
                if (op_reg.mode == OP_ADDI || op_reg.mode == OP_SUBI
                    || op_reg.mode == OP_MULTI || op_reg.mode == OP_DIVI
                    || op_reg.mode == OP_LSHIFTI || op_reg.mode == OP_RSHIFTI)
                    y_reg <= op_reg.imm;
                else
                    y_reg <= opb_reg;
            end
            S_EXEC:
            begin
                kind_reg    <= ex_kind;
                val_reg     <= ex_val;
                loc_reg     <= ex_loc;
                tgt_reg     <= ex_tgt;
                div_rem_reg <= 32'd0;
                div_quo_reg <= opa_reg[31] ? -opa_reg : opa_reg;
                div_dvs_reg <= y_reg[31] ? -y_reg : y_reg;
                div_neg_reg <= opa_reg[31] ^ y_reg[31];
            end
            S_MEM: val_reg <= mem_val;
            S_DIV:
            begin
                div_rem_reg <= div_rem_n;
                div_quo_reg <= div_quo_n;
                if (div_cnt_reg == 5'd31)
                    val_reg <= div_neg_reg ? -div_quo_n : div_quo_n;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_reg.kind     <= kind_reg;
                    res_reg.value    <= (kind_reg == K_ERR) ? 32'd0 : val_reg;
                    res_reg.location <= loc_reg;
                    res_reg.target   <= tgt_reg;
                end
            end
            default: ;
        endcase
    end

    `ROX_ASSERT_NOW(a_clear_stalls, state_reg == S_CLEAR, op_stall, "accept during clear")
    `ROX_ASSERT_NOW(a_rf_write_src, rf_we && state_reg != S_CLEAR,
        state_reg == S_DONE && kind_reg == K_REG, "stray register write")
    `ROX_ASSERT_NOW(a_err_clean, res_valid && res.kind == K_ERR,
        res.value == 32'd0 && res.location == 16'd0, "error result carries data")
    `ROX_ASSERT_NEXT(a_div_exit, state_reg == S_DIV,
        state_reg == S_DIV || state_reg == S_DONE, "divide left early")

endmodule

// ----- sim/risc_operation_executor_checker.sv -----
module risc_operation_executor_checker
    import rox_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic op_valid,
    input  logic op_stall,
    input  op_t  op,
    input  logic res_valid,
    input  logic res_stall,
    input  res_t res,
    output int   error_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] regs [NUM_REGS];
    logic [7:0]  mem [MEM_BYTES];
    res_t        expected_results [$];

    assign pending = expected_results.size();

    function automatic logic [31:0] byte_sext(logic [31:0] v);
        return {{24{v[7]}}, v[7:0]};
    endfunction

    function automatic bit fits(logic [31:0] a, logic [31:0] size);
        return a <= 32'(MEM_BYTES) - size;
    endfunction

    function automatic logic [31:0] word_at(logic [31:0] a);
        return {mem[a], mem[a + 1], mem[a + 2], mem[a + 3]};
    endfunction

    // executes one operation against the shadow state and returns its result
    function automatic res_t execute_op(op_t o);
        res_t               r;
        logic [31:0]        ra, rb, y, addr, val;
        logic signed [31:0] sa, sy;
        logic [2:0]         kind;
        logic [15:0]        loc, tgt;
        ra = regs[o.src_a % NUM_REGS];
        rb = regs[o.src_b % NUM_REGS];
        y = rb;
        kind = K_NONE;
        val = '0;
        loc = '0;
        tgt = '0;
        addr = '0;
        if (o.mode inside {OP_ADDI, OP_SUBI, OP_MULTI, OP_DIVI, OP_LSHIFTI, OP_RSHIFTI})
            y = o.imm;
        case (o.mode)
            OP_ADD, OP_ADDI: begin val = ra + y; kind = K_REG; end
            OP_SUB, OP_SUBI: begin val = ra - y; kind = K_REG; end
            OP_MULT, OP_MULTI: begin val = ra * y; kind = K_REG; end
            OP_DIV, OP_DIVI:
            begin
                if (y == 0)
                    kind = K_ERR;
                else
                begin
                    sa = ra;
                    sy = y;
                    if (ra == 32'h8000_0000 && y == 32'hFFFF_FFFF)
                        val = 32'h8000_0000;
                    else
                        val = sa / sy;
                    kind = K_REG;
                end
            end
            OP_LSHIFT, OP_LSHIFTI: begin val = ra << y[4:0]; kind = K_REG; end
            OP_RSHIFT, OP_RSHIFTI:
            begin
                sa = ra;
                val = sa >>> y[4:0];
                kind = K_REG;
            end
            OP_AND: begin val = ra & rb; kind = K_REG; end
            OP_OR: begin val = ra | rb; kind = K_REG; end
            OP_XOR: begin val = ra ^ rb; kind = K_REG; end
            OP_LOADI: begin val = o.imm; kind = K_REG; end
            OP_LOAD, OP_LOADAI, OP_LOADAO, OP_CLOAD, OP_CLOADAI, OP_CLOADAO:
            begin
                addr = ra;
                if (o.mode == OP_LOADAI || o.mode == OP_CLOADAI) addr += o.imm;
                if (o.mode == OP_LOADAO || o.mode == OP_CLOADAO) addr += rb;
                if (o.mode <= OP_LOADAO)
                begin
                    if (!fits(addr, 4)) kind = K_ERR;
                    else begin val = word_at(addr); kind = K_REG; end
                end
                else
                begin
                    if (!fits(addr, 1)) kind = K_ERR;
                    else begin val = byte_sext(mem[addr]); kind = K_REG; end
                end
            end
            OP_STORE, OP_STOREAI, OP_STOREAO, OP_CSTORE, OP_CSTOREAI, OP_CSTOREAO:
            begin
                addr = regs[o.dst_a % NUM_REGS];
                if (o.mode == OP_STOREAI || o.mode == OP_CSTOREAI) addr += o.imm;
                if (o.mode == OP_STOREAO || o.mode == OP_CSTOREAO)
                    addr += regs[o.dst_b % NUM_REGS];
                if (o.mode <= OP_STOREAO)
                begin
                    if (!fits(addr, 4)) kind = K_ERR;
                    else
                    begin
                        for (int i = 0; i < 4; i++)
                            mem[addr + i] = ra[31 - 8*i -: 8];
                        val = ra;
                        loc = addr[15:0];
                        kind = K_MEM;
                    end
                end
                else
                begin
                    if (!fits(addr, 1)) kind = K_ERR;
                    else
                    begin
                        mem[addr] = ra[7:0];
                        val = byte_sext(ra);
                        loc = addr[15:0];
                        kind = K_MEM;
                    end
                end
            end
            OP_BR: begin tgt = o.label_taken; kind = K_BRANCH; end
            OP_CBR:
            begin
                tgt = (ra != 0) ? o.label_taken : o.label_fallthrough;
                kind = K_BRANCH;
            end
            OP_CMPLT: begin val = $signed(ra) < $signed(rb); kind = K_REG; end
            OP_CMPLE: begin val = $signed(ra) <= $signed(rb); kind = K_REG; end
            OP_CMPEQ: begin val = ra == rb; kind = K_REG; end
            OP_CMPNE: begin val = ra != rb; kind = K_REG; end
            OP_CMPGE: begin val = $signed(ra) >= $signed(rb); kind = K_REG; end
            OP_CMPGT: begin val = $signed(ra) > $signed(rb); kind = K_REG; end
            OP_I2I: begin val = ra; kind = K_REG; end
            OP_C2C, OP_C2I, OP_I2C: begin val = byte_sext(ra); kind = K_REG; end
            OP_OUTPUT, OP_OUTPUTAI:
            begin
                addr = o.imm;
                if (o.mode == OP_OUTPUTAI) addr += ra;
                if (!fits(addr, 4)) kind = K_ERR;
                else begin val = word_at(addr); kind = K_DISP; end
            end
            OP_COUTPUT:
            begin
                addr = o.imm;
                if (!fits(addr, 1)) kind = K_ERR;
                else begin val = byte_sext(mem[addr]); kind = K_DISP; end
            end
            default: ;
        endcase
        if (kind == K_REG)
        begin
            loc = 16'(o.dst_a % NUM_REGS);
            regs[o.dst_a % NUM_REGS] = val;
        end
        if (kind == K_ERR)
            val = '0;
        r.kind = kind;
        r.value = val;
        r.location = loc;
        r.target = tgt;
        return r;
    endfunction

    initial
    begin
        error_count = 0;
        foreach (regs[i]) regs[i] = '0;
        foreach (mem[i]) mem[i] = '0;
    end

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n)
        begin
            if (op_valid && !op_stall)
                expected_results.push_back(execute_op(op));
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction: %p", res);
                    error_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (res.kind !== e.kind)
                    begin
                        $error("kind: expected %0d actual %0d", e.kind, res.kind);
                        error_count++;
                    end
                    if (res.value !== e.value)
                    begin
                        $error("value: expected %h actual %h", e.value, res.value);
                        error_count++;
                    end
                    if (res.location !== e.location)
                    begin
                        $error("location: expected %h actual %h", e.location, res.location);
                        error_count++;
                    end
                    if (res.target !== e.target)
                    begin
                        $error("target: expected %h actual %h", e.target, res.target);
                        error_count++;
                    end
                end
            end
        end
    end
endmodule

// ----- sim/risc_operation_executor_tb.sv -----
module risc_operation_executor_tb;
    import rox_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 80000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic op_valid = 1'b0;
    logic op_stall;
    op_t  op = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;
    int   error_count;
    int   pending;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_results = 1'b0;
    bit   stim_done = 1'b0;
    int   quiet_cycles = 0;

    always #10 clk = ~clk;

    risc_operation_executor u_dut (
        .clk(clk), .rst_n(rst_n), .op_valid(op_valid), .op_stall(op_stall), .op(op),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    risc_operation_executor_checker u_checker (
        .clk(clk), .rst_n(rst_n), .op_valid(op_valid), .op_stall(op_stall), .op(op),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .error_count(error_count), .pending(pending)
    );

    // receiver backpressure
    always @(posedge clk)
        res_stall <= hold_results || ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if ((op_valid && !op_stall) || (res_valid && !res_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // register index: mostly a small working set so values get reused
    function automatic logic [7:0] pick_reg();
        return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(64);
            4: return $urandom_range(MEM_BYTES + 8);
            default: return $urandom;
        endcase
    endfunction

    // valid stays high after acceptance so back-to-back transactions need no gap;
    // it drops on an idle cycle or when drain() starts
    task automatic send(op_t o);
        while ($urandom_range(99) < send_idle_pct)
        begin
            op_valid <= 1'b0;
            @(posedge clk);
        end
        op <= o;
        op_valid <= 1'b1;
        @(posedge clk);
        while (op_stall)
            @(posedge clk);
    endtask

    task automatic send_op(logic [5:0] m, logic [7:0] a, logic [7:0] b, logic [7:0] d,
                           logic [7:0] e, logic [31:0] k);
        op_t o;
        o.mode = m;
        o.src_a = a;
        o.src_b = b;
        o.dst_a = d;
        o.dst_b = e;
        o.imm = k;
        o.label_taken = 16'($urandom);
        o.label_fallthrough = 16'($urandom);
        send(o);
    endtask

    task automatic send_random();
        op_t o;
        o.mode = ($urandom_range(19) == 0) ? 6'($urandom_range(46, 63))
                                           : 6'($urandom_range(45));
        o.src_a = pick_reg();
        o.src_b = pick_reg();
        o.dst_a = pick_reg();
        o.dst_b = pick_reg();
        o.imm = pick_value();
        if (o.mode inside {OP_LOADAI, OP_CLOADAI, OP_STOREAI, OP_CSTOREAI, OP_OUTPUT,
                           OP_COUTPUT, OP_OUTPUTAI} && $urandom_range(3) != 0)
            o.imm = $urandom_range(MEM_BYTES + 2);
        o.label_taken = 16'($urandom);
        o.label_fallthrough = 16'($urandom);
        send(o);
    endtask

    task automatic drain();
        op_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // directed: extremes, overflow, errors, address edges
        send_op(OP_LOADI, 0, 0, 1, 0, 32'h8000_0000);
        send_op(OP_LOADI, 0, 0, 2, 0, 32'hFFFF_FFFF);
        send_op(OP_LOADI, 0, 0, 3, 0, 32'h7FFF_FFFF);
        send_op(OP_LOADI, 0, 0, 4, 0, 32'(MEM_BYTES - 4));
        send_op(OP_DIV, 1, 2, 5, 0, 0);
        send_op(OP_DIV, 1, 0, 6, 0, 0);
        send_op(OP_DIVI, 3, 0, 6, 0, 32'hFFFF_FFFD);
        send_op(OP_MULT, 3, 3, 7, 0, 0);
        send_op(OP_RSHIFTI, 1, 0, 7, 0, 32'h0000_003F);
        send_op(OP_LSHIFT, 3, 2, 7, 0, 0);
        send_op(OP_STORE, 3, 0, 4, 0, 0);
        send_op(OP_STOREAI, 3, 0, 4, 0, 1);
        send_op(OP_CSTOREAI, 2, 0, 4, 0, 3);
        send_op(OP_CSTOREAI, 2, 0, 4, 0, 4);
        send_op(OP_LOAD, 4, 0, 8, 0, 0);
        send_op(OP_CLOADAO, 4, 4, 8, 0, 0);
        send_op(OP_OUTPUT, 0, 0, 0, 0, 32'(MEM_BYTES - 4));
        send_op(OP_COUTPUT, 0, 0, 0, 0, 32'(MEM_BYTES - 1));
        send_op(OP_OUTPUTAI, 2, 0, 0, 0, 32'h0);
        send_op(OP_CBR, 0, 0, 0, 0, 0);
        send_op(OP_CBR, 2, 0, 0, 0, 0);
        send_op(OP_CMPLE, 1, 3, 9, 0, 0);
        send_op(OP_C2I, 2, 0, 255, 0, 0);
        send_op(6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        for (int m = 0; m <= 45; m++)
            send_op(6'(m), pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_value());
        drain();

        // long receiver hold-off with the sender still offering
        hold_results = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_results = 1'b0;
            end
            repeat (10) send_random();
        join
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 53 : 0;
            recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 27 : 0;
            for (int i = 0; i < 340; i++)
                send_random();
        end
        stim_done = 1'b1;
        drain();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/rox_pkg.sv
sv/risc_operation_executor.sv
sim/risc_operation_executor_checker.sv
sim/risc_operation_executor_tb.sv
